>>> src/multi_stream_timestamp_aligner_macros.svh
// Assertion macros for the timestamp aligner.
// They use the clk_i and rst_ni of the module that includes this file.
`ifndef MULTI_STREAM_TIMESTAMP_ALIGNER_MACROS_SVH
`define MULTI_STREAM_TIMESTAMP_ALIGNER_MACROS_SVH

`ifndef SYNTHESIS

`define MSTA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("msta assertion failed");

`define MSTA_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("msta forbidden condition");

`else

`define MSTA_ASSERT(lbl, prop)

`define MSTA_ASSERT_NEVER(lbl, expr)

`endif

`endif

>>> src/msta_pkg.sv
package msta_pkg;

  localparam int NUM_STREAMS = 4;
  localparam int SID_BITS    = 2;
  localparam int SYNC_BITS   = 32;

  localparam logic [SID_BITS-1:0] SID_IMAGE = 2'd0;
  localparam logic [SID_BITS-1:0] SID_DEPTH = 2'd1;
  localparam logic [SID_BITS-1:0] SID_SCAN  = 2'd2;
  localparam logic [SID_BITS-1:0] SID_CLOUD = 2'd3;

  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_OFFSET    = 1'b1;

  localparam longint unsigned THRESHOLD_RST = 64'd20000;

  // control from the sequencer to the shared key/spread unit
  typedef struct packed {
    logic                key_en;
    logic                cam;
    logic                cmp_en;
    logic                first;
    logic [SID_BITS-1:0] sid;
    logic                spread_en;
  } msta_ctrl_t;

  typedef struct packed {
    logic                over;
    logic [SID_BITS-1:0] lo_idx;
  } msta_stat_t;

endpackage

>>> src/msta_queue_ram.sv
module msta_queue_ram #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 64
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/msta_spread_unit.sv
module msta_spread_unit #(
  parameter int TIME_BITS = 48
) (
  input  logic                    clk_i,
  input  msta_pkg::msta_ctrl_t    ctrl_i,
  input  logic [TIME_BITS-1:0]    time_i,
  input  logic [TIME_BITS-1:0]    offset_i,
  input  logic [TIME_BITS-1:0]    threshold_i,
  output msta_pkg::msta_stat_t    stat_o
);
  import msta_pkg::*;

  localparam int KW = TIME_BITS + 1;
  localparam logic [KW-1:0] BIAS = KW'(1) << (TIME_BITS - 1);

  logic [KW-1:0]       key_d;
  logic [KW-1:0]       key_q;
  logic [KW-1:0]       lo_key_q;
  logic [KW-1:0]       hi_key_q;
  logic [SID_BITS-1:0] lo_idx_q;
  logic                over_q;
  logic [KW-1:0]       off_ext;
  logic [KW-1:0]       spread;

  // biased key stays in 0 .. 2^KW-2, so modular add is exact
  assign off_ext = ctrl_i.cam ? {offset_i[TIME_BITS-1], offset_i} : '0;
  assign key_d   = {1'b0, time_i} + BIAS + off_ext;
  assign spread  = hi_key_q - lo_key_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.key_en) begin
      key_q <= key_d;
    end
    if (ctrl_i.cmp_en) begin
      if (ctrl_i.first) begin
        lo_key_q <= key_q;
        hi_key_q <= key_q;
        lo_idx_q <= ctrl_i.sid;
      end else begin
        if (key_q < lo_key_q) begin
          lo_key_q <= key_q;
          lo_idx_q <= ctrl_i.sid;
        end
        if (key_q > hi_key_q) begin
          hi_key_q <= key_q;
        end
      end
    end
    if (ctrl_i.spread_en) begin
      over_q <= spread > {1'b0, threshold_i};
    end
  end

  assign stat_o.over   = over_q;
  assign stat_o.lo_idx = lo_idx_q;

endmodule

>>> src/multi_stream_timestamp_aligner.sv
// Aligns four timestamped streams (0 image, 1 depth, 2 laser scan, 3 point
// cloud). Each input word is pushed into its stream's queue (a full queue
// loses its oldest entry), then the queue heads are compared one stream at a
// time by a shared key/compare unit: image and depth times get the camera
// offset added, and if the spread between earliest and latest head exceeds
// the threshold the earliest head is dropped (lowest stream on ties; when the
// dropped head is image or depth and the image and depth heads carry equal
// raw times, both are dropped) and the comparison repeats. A match emits the
// four tags with a wrapping sync index and pops all heads. After its push, an
// input word runs one head comparison per round (each dropping round and the
// matching round), and a matched set then waits for the output register to
// free up; the number of comparisons is set by how many heads get dropped, at
// most about four queue depths per word. The queues share one single-port-read
// memory, which together with the one compare unit makes each round read and
// compare the heads one stream at a time. The block is not ready while a word
// is in work; a matched set waits in the output register without blocking
// the next input word until the next emit.
module multi_stream_timestamp_aligner #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16,
  parameter int TIME_BITS   = 48,
  localparam int S_DATA_W   = ((TIME_BITS + TAG_BITS + 7) / 8) * 8,
  localparam int M_DATA_W   = ((4 * TAG_BITS + 32 + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [TIME_BITS-1:0]          cfg_wdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // timestamp_us, payload_tag
  input  logic [S_DATA_W-1:0]           s_axis_tdata_i,
  // stream_id
  input  logic [msta_pkg::SID_BITS-1:0] s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // image_tag, depth_tag, scan_tag, cloud_tag, sync_index
  output logic [M_DATA_W-1:0]           m_axis_tdata_o
);
  import msta_pkg::*;

  `include "multi_stream_timestamp_aligner_macros.svh"

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = SID_BITS + PTR_W;
  localparam int ENT_W  = TIME_BITS + TAG_BITS;
  localparam int OUT_W  = 4 * TAG_BITS + SYNC_BITS;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PUSH   = 3'd1;
  localparam logic [2:0] ST_CHECK  = 3'd2;
  localparam logic [2:0] ST_KEY    = 3'd3;
  localparam logic [2:0] ST_CMP    = 3'd4;
  localparam logic [2:0] ST_SPREAD = 3'd5;
  localparam logic [2:0] ST_DECIDE = 3'd6;
  localparam logic [2:0] ST_EMIT   = 3'd7;

  logic [2:0]           state_q, state_d;
  logic [SID_BITS-1:0]  k_q, k_d;
  logic [SID_BITS-1:0]  sid_q;
  logic [ENT_W-1:0]     entry_q;
  logic [PTR_W-1:0]     rd_ptr_q [NUM_STREAMS];
  logic [PTR_W-1:0]     wr_ptr_q [NUM_STREAMS];
  logic [CNT_W-1:0]     cnt_q    [NUM_STREAMS];
  logic [TAG_BITS-1:0]  tag_q    [NUM_STREAMS];
  logic [TIME_BITS-1:0] t_img_q, t_dep_q;
  logic [TIME_BITS-1:0] thr_q, off_q;
  logic [SYNC_BITS-1:0] sync_q;
  logic                 m_valid_q;
  logic [OUT_W-1:0]     out_q;

  logic [NUM_STREAMS-1:0] push_mask, pop_mask;
  logic                   all_nonempty;
  logic                   out_free;
  logic                   emit_go;
  logic                   in_acc;
  logic                   re;
  logic [SID_BITS-1:0]    rd_sel;
  logic [ENT_W-1:0]       rdata;
  logic                   full_sel;
  logic                   same_cam;
  msta_ctrl_t             ctrl;
  msta_stat_t             stat;

  function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign emit_go         = (state_q == ST_EMIT) && out_free;
  assign full_sel        = (cnt_q[sid_q] == CNT_W'(QUEUE_DEPTH));
  assign same_cam        = (t_img_q == t_dep_q);

  always_comb begin
    all_nonempty = 1'b1;
    for (int s = 0; s < NUM_STREAMS; s++) begin
      if (cnt_q[s] == '0) begin
        all_nonempty = 1'b0;
      end
    end
  end

  assign rd_sel = (state_q == ST_CHECK) ? SID_IMAGE : k_q + 1'b1;
  assign re     = ((state_q == ST_CHECK) && all_nonempty) ||
                  ((state_q == ST_CMP) && (k_q != SID_CLOUD));

  msta_queue_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (ENT_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_PUSH),
    .waddr_i ({sid_q, wr_ptr_q[sid_q]}),
    .wdata_i (entry_q),
    .re_i    (re),
    .raddr_i ({rd_sel, rd_ptr_q[rd_sel]}),
    .rdata_o (rdata)
  );

  assign ctrl.key_en    = (state_q == ST_KEY);
  assign ctrl.cam       = !k_q[1];
  assign ctrl.cmp_en    = (state_q == ST_CMP);
  assign ctrl.first     = (k_q == SID_IMAGE);
  assign ctrl.sid       = k_q;
  assign ctrl.spread_en = (state_q == ST_SPREAD);

  msta_spread_unit #(
    .TIME_BITS (TIME_BITS)
  ) u_spread (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .time_i      (rdata[TIME_BITS-1:0]),
    .offset_i    (off_q),
    .threshold_i (thr_q),
    .stat_o      (stat)
  );

  always_comb begin
    push_mask = '0;
    pop_mask  = '0;
    unique case (state_q)
      ST_PUSH: begin
        push_mask[sid_q] = 1'b1;
        if (full_sel) begin
          pop_mask[sid_q] = 1'b1;
        end
      end
      ST_DECIDE: begin
        if (stat.over) begin
          pop_mask[stat.lo_idx] = 1'b1;
          if (!stat.lo_idx[1] && same_cam) begin
            pop_mask[{1'b0, ~stat.lo_idx[0]}] = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          pop_mask = '1;
        end
      end
      default: begin
        push_mask = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        k_d     = SID_IMAGE;
        state_d = all_nonempty ? ST_KEY : ST_IDLE;
      end
      ST_KEY: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (k_q == SID_CLOUD) begin
          state_d = ST_SPREAD;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_KEY;
        end
      end
      ST_SPREAD: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_d = stat.over ? ST_CHECK : ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      k_q       <= '0;
      sync_q    <= '0;
      m_valid_q <= 1'b0;
      thr_q     <= TIME_BITS'(THRESHOLD_RST);
      off_q     <= '0;
      for (int s = 0; s < NUM_STREAMS; s++) begin
        rd_ptr_q[s] <= '0;
        wr_ptr_q[s] <= '0;
        cnt_q[s]    <= '0;
      end
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_THRESHOLD) begin
          thr_q <= cfg_wdata_i;
        end else begin
          off_q <= cfg_wdata_i;
        end
      end
      for (int s = 0; s < NUM_STREAMS; s++) begin
        if (pop_mask[s]) begin
          rd_ptr_q[s] <= next_ptr(rd_ptr_q[s]);
        end
        if (push_mask[s]) begin
          wr_ptr_q[s] <= next_ptr(wr_ptr_q[s]);
        end
        cnt_q[s] <= cnt_q[s] + CNT_W'(push_mask[s]) - CNT_W'(pop_mask[s]);
      end
      if (emit_go) begin
        m_valid_q <= 1'b1;
        sync_q    <= sync_q + 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sid_q   <= s_axis_tuser_i;
      entry_q <= {s_axis_tdata_i[TIME_BITS +: TAG_BITS], s_axis_tdata_i[TIME_BITS-1:0]};
    end
    if (state_q == ST_KEY) begin
      tag_q[k_q] <= rdata[TIME_BITS +: TAG_BITS];
      if (k_q == SID_IMAGE) begin
        t_img_q <= rdata[TIME_BITS-1:0];
      end
      if (k_q == SID_DEPTH) begin
        t_dep_q <= rdata[TIME_BITS-1:0];
      end
    end
    if (emit_go) begin
      out_q <= {sync_q, tag_q[SID_CLOUD], tag_q[SID_SCAN], tag_q[SID_DEPTH],
                tag_q[SID_IMAGE]};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = M_DATA_W'(out_q);

  `MSTA_ASSERT(a_accept_pushes, in_acc |=> (state_q == ST_PUSH))
  `MSTA_ASSERT(a_push_nonempty, (state_q == ST_PUSH) |=> (cnt_q[$past(sid_q)] != '0))
  `MSTA_ASSERT(a_emit_counts, emit_go |=> (sync_q == $past(sync_q) + 1'b1) && m_valid_q)
  `MSTA_ASSERT_NEVER(a_decide_empty, (state_q == ST_DECIDE) && !all_nonempty)

endmodule
